// ===== rtl/rc5_pkg.sv =====
// Shared types and constants for the RC5 infrared decoder.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rc5_pkg;

  localparam int unsigned DUR_W   = 16;
  localparam int unsigned CODE_W  = 14;
  localparam logic [DUR_W-1:0] SHORT_MAX_RESET = 16'd1334;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_BUSY = 2'd0,
    STATUS_DONE = 2'd1,
    STATUS_ERR  = 2'd2
  } status_t;

  // Half-bit phase tracker, one-hot
  typedef enum logic [4:0] {
    ST_START = 5'b00001,
    ST_LO    = 5'b00010,
    ST_LO2   = 5'b00100,
    ST_HI    = 5'b01000,
    ST_HI2   = 5'b10000
  } dec_state_t;

endpackage

`default_nettype wire

// ===== rtl/rc5_ir_if.sv =====
// Valid/ready channel interfaces: segment input, decode result, config write.
// Depends on rc5_pkg for widths and the status type.
`timescale 1ns / 1ps
`default_nettype none

interface rc5_seg_if;
  logic                      valid;
  logic                      ready;
  logic [rc5_pkg::DUR_W-1:0] duration;
  logic                      is_pulse;

  modport source (output valid, output duration, output is_pulse, input ready);
  modport sink   (input valid, input duration, input is_pulse, output ready);
endinterface

interface rc5_res_if;
  logic                       valid;
  logic                       ready;
  rc5_pkg::status_t           status;
  logic [rc5_pkg::CODE_W-1:0] code;

  modport source (output valid, output status, output code, input ready);
  modport sink   (input valid, input status, input code, output ready);
endinterface

interface rc5_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rc5_pkg::DUR_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rc5_manchester_ir_decoder_unit.sv =====
// RC5 Manchester infrared decoder, top level.
// Depends on rc5_pkg and the channel interfaces in rc5_ir_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Takes one measured level segment (duration, pulse or space) per item and
// returns exactly one result item: frame in progress, frame complete with the
// received code, or framing error. A segment shorter than the configured
// short_max threshold is a short half bit. The decoder state is updated in the
// cycle the segment is accepted and the result lands in an output register,
// so one segment per clock is sustained; the input stalls only while a
// result is held because the result channel is not ready. A frame holds
// FRAME_BITS bits; the code field shows the low 14 bits of the shift
// register. The threshold register is written through the cfg channel, which
// is always ready, and must only be written while the decoder is idle.
module rc5_manchester_ir_decoder_unit #(
  parameter int unsigned FRAME_BITS = 14
) (
  input  wire         clk,
  input  wire         rst,
  rc5_seg_if.sink     seg,
  rc5_res_if.source   res,
  rc5_cfg_if.sink     cfg
);

  localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BITS);

  logic [rc5_pkg::DUR_W-1:0] short_max;
  rc5_pkg::dec_state_t       state, state_next;
  logic [FRAME_BITS-1:0]     code_shift, code_shift_next;
  logic [CNT_W-1:0]          bit_count, bit_count_next;

  logic                       out_valid;
  rc5_pkg::status_t           out_status, status_next;
  logic [rc5_pkg::CODE_W-1:0] out_code, code_next;

  logic seg_accept;
  logic is_short;
  logic bad;
  rc5_pkg::dec_state_t       phase;
  logic [FRAME_BITS-1:0]     shift_adv;
  logic [CNT_W-1:0]          count_adv;
  logic [rc5_pkg::CODE_W+FRAME_BITS-1:0] code_ext_cur, code_ext_adv;

  assign seg.ready  = !out_valid || res.ready;
  assign seg_accept = seg.valid && seg.ready;
  assign cfg.ready  = 1'b1;

  assign res.valid  = out_valid;
  assign res.status = out_status;
  assign res.code   = out_code;

  assign is_short = seg.duration < short_max;

  // Next phase from the current phase and the segment kind
  always_comb begin
    bad   = 1'b0;
    phase = state;
    unique case (state)
      rc5_pkg::ST_START: phase = rc5_pkg::ST_LO;
      rc5_pkg::ST_LO: begin
        bad   = !seg.is_pulse;
        phase = is_short ? rc5_pkg::ST_LO2 : rc5_pkg::ST_HI;
      end
      rc5_pkg::ST_LO2: begin
        bad   = !(is_short && !seg.is_pulse);
        phase = rc5_pkg::ST_LO;
      end
      rc5_pkg::ST_HI: begin
        bad   = seg.is_pulse;
        phase = is_short ? rc5_pkg::ST_HI2 : rc5_pkg::ST_LO;
      end
      rc5_pkg::ST_HI2: begin
        bad   = !(is_short && seg.is_pulse);
        phase = rc5_pkg::ST_HI;
      end
      default: bad = 1'b1;
    endcase
  end

  // Shift register and count after this segment, if a bit cell completes
  always_comb begin
    shift_adv = code_shift;
    count_adv = bit_count;
    if (state == rc5_pkg::ST_START) begin
      shift_adv = code_shift | FRAME_BITS'(1);
      count_adv = bit_count + CNT_W'(1);
    end else if (phase == rc5_pkg::ST_HI) begin
      shift_adv = {code_shift[FRAME_BITS-2:0], 1'b0};
      count_adv = bit_count + CNT_W'(1);
    end else if (phase == rc5_pkg::ST_LO) begin
      shift_adv = {code_shift[FRAME_BITS-2:0], 1'b1};
      count_adv = bit_count + CNT_W'(1);
    end
  end

  assign code_ext_cur = {{rc5_pkg::CODE_W{1'b0}}, code_shift};
  assign code_ext_adv = {{rc5_pkg::CODE_W{1'b0}}, shift_adv};

  always_comb begin
    state_next      = phase;
    code_shift_next = shift_adv;
    bit_count_next  = count_adv;
    status_next     = rc5_pkg::STATUS_BUSY;
    code_next       = '0;
    if (bit_count >= CNT_FULL) begin
      // Frame already full: emit regardless of the segment
      state_next      = rc5_pkg::ST_START;
      code_shift_next = '0;
      bit_count_next  = '0;
      status_next     = rc5_pkg::STATUS_DONE;
      code_next       = code_ext_cur[rc5_pkg::CODE_W-1:0];
    end else if (state == rc5_pkg::ST_START) begin
      state_next = rc5_pkg::ST_LO;
    end else if (bad) begin
      state_next      = rc5_pkg::ST_START;
      code_shift_next = '0;
      bit_count_next  = '0;
      status_next     = rc5_pkg::STATUS_ERR;
    end else if (count_adv >= CNT_FULL && seg.is_pulse) begin
      state_next      = rc5_pkg::ST_START;
      code_shift_next = '0;
      bit_count_next  = '0;
      status_next     = rc5_pkg::STATUS_DONE;
      code_next       = code_ext_adv[rc5_pkg::CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_max  <= rc5_pkg::SHORT_MAX_RESET;
      state      <= rc5_pkg::ST_START;
      code_shift <= '0;
      bit_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        short_max <= cfg.data;
      end
      if (seg_accept) begin
        state      <= state_next;
        code_shift <= code_shift_next;
        bit_count  <= bit_count_next;
        out_valid  <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (seg_accept) begin
      out_status <= status_next;
      out_code   <= code_next;
    end
  end

endmodule

`default_nettype wire
